[sv/srec_pkg.sv]
package srec_pkg;

  // ascii characters the parser looks for
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SUM   = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_HEX   = 3'd4;

  // record type that is not allowed
  localparam logic [3:0] TYPE_RESERVED = 4'd4;

  // width of the packed output data word
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic        kind;
    logic [3:0]  record_type;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [2:0]  status;
  } srec_res_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // number of address bytes for a record type
  function automatic logic [2:0] addr_size(input logic [3:0] t);
    logic [2:0] r;
    unique case (t)
      4'd2, 4'd6, 4'd8: r = 3'd3;
      4'd3, 4'd7:       r = 3'd4;
      default:          r = 3'd2;
    endcase
    return r;
  endfunction

endpackage

[sv/srec_parse.sv]
module srec_parse
  import srec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      char_fire,
  input  logic [7:0] char_in,
  output logic      res_valid,
  output srec_res_t res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  rec_type_r, rec_type_nxt;
  logic [3:0]  high_nib_r, high_nib_nxt;
  logic        nib_tog_r, nib_tog_nxt;
  logic [2:0]  addr_left_r, addr_left_nxt;
  logic [7:0]  data_left_r, data_left_nxt;
  logic [31:0] rec_addr_r, rec_addr_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic [4:0] hex;
  logic [7:0] byte_val;
  logic [2:0] asz;
  logic       is_digit;
  logic [3:0] type_digit;
  logic [2:0] addr_left_dec;

  assign hex           = hex_decode(char_in);
  assign byte_val      = {high_nib_r, hex[3:0]};
  assign asz           = addr_size(rec_type_r);
  assign is_digit      = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign type_digit    = is_digit ? char_in[3:0] : 4'd0;
  assign addr_left_dec = addr_left_r - 3'd1;

  // next state and result for one character
  always_comb begin
    phase_nxt     = phase_r;
    rec_type_nxt  = rec_type_r;
    high_nib_nxt  = high_nib_r;
    nib_tog_nxt   = nib_tog_r;
    addr_left_nxt = addr_left_r;
    data_left_nxt = data_left_r;
    rec_addr_nxt  = rec_addr_r;
    offset_nxt    = offset_r;
    sum_nxt       = sum_r;
    res_valid          = 1'b0;
    res.kind           = KIND_STATUS;
    res.record_type    = rec_type_r;
    res.byte_address   = rec_addr_r;
    res.data_byte      = 8'd0;
    res.status         = ST_OK;
    if (char_fire) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (char_in == CH_S) begin
            phase_nxt = PH_TYPE;
            rec_type_nxt = 4'd0;  high_nib_nxt = 4'd0; nib_tog_nxt = 1'b0;
            addr_left_nxt = 3'd0; data_left_nxt = 8'd0; rec_addr_nxt = 32'd0;
            offset_nxt = 8'd0;    sum_nxt = 8'd0;
          end
        end
        PH_TYPE: begin
          if (is_digit && type_digit != TYPE_RESERVED) begin
            rec_type_nxt = type_digit;
            phase_nxt    = PH_COUNT;
          end else begin
            res_valid       = 1'b1;
            res.record_type = type_digit;
            res.status      = ST_BAD_TYPE;
            // an S here reopens a record right away
            if (char_in == CH_S) begin
              phase_nxt = PH_TYPE;
              rec_type_nxt = 4'd0;  high_nib_nxt = 4'd0; nib_tog_nxt = 1'b0;
              addr_left_nxt = 3'd0; data_left_nxt = 8'd0; rec_addr_nxt = 32'd0;
              offset_nxt = 8'd0;    sum_nxt = 8'd0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_SUM: begin
          if (!hex[4]) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_HEX;
            if (char_in == CH_S) begin
              phase_nxt = PH_TYPE;
              rec_type_nxt = 4'd0;  high_nib_nxt = 4'd0; nib_tog_nxt = 1'b0;
              addr_left_nxt = 3'd0; data_left_nxt = 8'd0; rec_addr_nxt = 32'd0;
              offset_nxt = 8'd0;    sum_nxt = 8'd0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else if (!nib_tog_r) begin
            high_nib_nxt = hex[3:0];
            nib_tog_nxt  = 1'b1;
          end else begin
            nib_tog_nxt = 1'b0;
            unique case (phase_r)
              PH_COUNT: begin
                if (byte_val < {5'd0, asz} + 8'd1) begin
                  phase_nxt  = PH_IDLE;
                  res_valid  = 1'b1;
                  res.status = ST_BAD_COUNT;
                end else begin
                  sum_nxt       = byte_val;
                  addr_left_nxt = asz;
                  data_left_nxt = byte_val - {5'd0, asz} - 8'd1;
                  phase_nxt     = PH_ADDR;
                end
              end
              PH_ADDR: begin
                rec_addr_nxt  = {rec_addr_r[23:0], byte_val};
                sum_nxt       = sum_r + byte_val;
                addr_left_nxt = addr_left_dec;
                if (addr_left_dec == 3'd0) begin
                  phase_nxt = (data_left_r == 8'd0) ? PH_SUM : PH_DATA;
                end
              end
              PH_DATA: begin
                res_valid        = 1'b1;
                res.kind         = KIND_DATA;
                res.byte_address = rec_addr_r + {24'd0, offset_r};
                res.data_byte    = byte_val;
                sum_nxt          = sum_r + byte_val;
                offset_nxt       = offset_r + 8'd1;
                data_left_nxt    = data_left_r - 8'd1;
                if (data_left_r == 8'd1) begin
                  phase_nxt = PH_SUM;
                end
              end
              default: begin
                // checksum byte closes the record
                phase_nxt  = PH_IDLE;
                res_valid  = 1'b1;
                res.status = (byte_val == ~sum_r) ? ST_OK : ST_BAD_SUM;
              end
            endcase
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      rec_type_r  <= 4'd0;
      high_nib_r  <= 4'd0;
      nib_tog_r   <= 1'b0;
      addr_left_r <= 3'd0;
      data_left_r <= 8'd0;
      rec_addr_r  <= 32'd0;
      offset_r    <= 8'd0;
      sum_r       <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      rec_type_r  <= rec_type_nxt;
      high_nib_r  <= high_nib_nxt;
      nib_tog_r   <= nib_tog_nxt;
      addr_left_r <= addr_left_nxt;
      data_left_r <= data_left_nxt;
      rec_addr_r  <= rec_addr_nxt;
      offset_r    <= offset_nxt;
      sum_r       <= sum_nxt;
    end
  end

endmodule

[sv/srec_record_parser.sv]
// Motorola S-record text parser.
// in_*  : one ASCII character per beat (in_tdata[7:0]).
// out_* : one result per beat; out_tuser is the kind (0 data byte,
//         1 end-of-record status). Data beats carry the byte and its
//         address, status beats carry the record address and the code
//         (ok, bad checksum, bad type, bad count, bad hex digit).
// Throughput: one character per cycle while in_tready is high. The parser
// state register updates directly from the incoming character, so
// that loop sets the rate.
// Results: a result is formed combinationally from the accepted
// character and registered in the output or skid register.
// Stall: results sit in an output register backed by a one-beat skid
// register; in_tready drops only when both are full, and nothing is lost.
// Reset (rst_n low, synchronous): the parser returns to waiting for 'S'
// and both output registers are emptied.
module srec_record_parser
  import srec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // char_in[7:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // record_type[3:0], byte_address[35:4],
                                            // data_byte[43:36], status[46:44], zero[47]
  output logic                  out_tuser   // kind[0]
);

  logic      in_fire;
  logic      res_valid;
  srec_res_t res;

  logic      out_valid_r, out_valid_nxt;
  srec_res_t out_res_r, out_res_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  srec_res_t skid_res_r, skid_res_nxt;
  logic      out_load;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  srec_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_fire (in_fire),
    .char_in   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with skid behind it
  assign out_load = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (out_load) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_res_nxt   = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  // pack result beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {1'b0, out_res_r.status, out_res_r.data_byte,
                       out_res_r.byte_address, out_res_r.record_type};

endmodule

[sv/srec_chk.sv]
module srec_chk
  import srec_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // input back-pressure only when a result is already waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tready && out_tvalid))
    else $error("input stalled with output free");

  // data beats carry no status and never the reserved type
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |->
      out_tdata[46:44] == ST_OK && out_tdata[3:0] != TYPE_RESERVED)
    else $error("bad fields in data beat");

  // status code stays in its range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[46:44] <= ST_BAD_HEX && out_tdata[47] == 1'b0)
    else $error("status code out of range");

endmodule

bind srec_record_parser srec_chk u_srec_chk (.*);
